// ----- src/stepper_tone_generator_assert.svh -----
// Assertion macros shared by the stepper tone generator RTL.
`ifndef STEPPER_TONE_GENERATOR_ASSERT_SVH
`define STEPPER_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stg_pkg.sv -----
// Types and constants of the stepper tone generator.
`default_nettype none

package stg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TURN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TURN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_POS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_STEPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_INTERVAL = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_LOW_TURN      = 8'd30;
    localparam logic [7:0]  RST_HIGH_TURN     = 8'd130;
    localparam logic [7:0]  RST_CENTER_POS    = 8'd80;
    localparam logic [7:0]  RST_HOME_STEPS    = 8'd200;
    localparam logic [15:0] RST_HOME_INTERVAL = 16'd40000;
    localparam logic [15:0] RST_TONE_PERIOD   = 16'hFFFF;

    // command bytes
    localparam logic [7:0] CMD_STOP       = 8'd1;
    localparam logic [7:0] CMD_PLAY       = 8'd2;
    localparam logic [7:0] CMD_INSTR      = 8'd3;
    localparam logic [7:0] CMD_TOGGLE_DIR = 8'd4;
    localparam logic [7:0] CMD_RESET      = 8'd5;

    localparam logic [7:0] MODE_OSC = 8'd0;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // parser phases
    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_MODE = 2'd3;

    // homing phases
    localparam logic [1:0] HP_DOWN = 2'd0;
    localparam logic [1:0] HP_UP   = 2'd1;
    localparam logic [1:0] HP_DONE = 2'd2;

    typedef struct packed {
        logic [7:0]  low_turn;
        logic [7:0]  high_turn;
        logic [7:0]  center_pos;
        logic [7:0]  home_steps;
        logic [15:0] home_interval;
    } t_cfg;

    typedef struct packed {
        logic step_out;
        logic dir_out;
        logic homing_busy;
        logic byte_dropped;
    } t_result;

endpackage

`default_nettype wire

// ----- src/stg_in_if.sv -----
// Input channel: command byte or timer tick.
`default_nettype none

interface stg_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/stg_out_if.sv -----
// Output channel: pin levels and status after each input word.
`default_nettype none

interface stg_out_if;
    logic valid;
    logic ready;
    logic step_out;
    logic dir_out;
    logic homing_busy;
    logic byte_dropped;

    modport source (
        output valid, output step_out, output dir_out,
        output homing_busy, output byte_dropped, input ready
    );
    modport sink (
        input valid, input step_out, input dir_out,
        input homing_busy, input byte_dropped, output ready
    );
endinterface

`default_nettype wire

// ----- src/stepper_tone_generator.sv -----
// Top level of the stepper tone generator: input stage, configuration registers, engine and result register.
`default_nettype none

`include "stepper_tone_generator_assert.svh"

// Stepper tone generator. Each input word is a command byte or a timer tick and
// yields exactly one result word with the step and direction pin levels, the
// homing flag and a flag for a byte dropped during homing. A word is taken into
// an input register, and once the result register is free or being emptied the
// engine updates all state while the result is loaded into the output register,
// so one word per cycle is sustained while the output is not stalled; the engine
// updates all its state for a word at once. Homing starts out of reset with
// 200 down toggles; configuration writes take effect from the next word.
module stepper_tone_generator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    stg_in_if.sink                            i_in,
    stg_out_if.source                         o_out,
    input  wire                               i_cfg_we,
    input  wire  [stg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [stg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import stg_pkg::*;

    logic       r_in_valid;
    logic       r_in_req_type;
    logic [7:0] r_in_rx_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_adv;
    logic       w_take;
    t_cfg       w_cfg;
    t_result    w_res;

    // advance when the result register is free or being emptied
    assign w_adv  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || w_adv;

    stg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    stg_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_adv),
        .i_req_type (r_in_req_type),
        .i_rx_byte  (r_in_rx_byte),
        .i_cfg      (w_cfg),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_req_type <= i_in.req_type;
            r_in_rx_byte  <= i_in.rx_byte;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.step_out     = r_out.step_out;
    assign o_out.dir_out      = r_out.dir_out;
    assign o_out.homing_busy  = r_out.homing_busy;
    assign o_out.byte_dropped = r_out.byte_dropped;

    `STG_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid, "processed word lost before result register")
    `STG_ASSERT_NEXT(a_stall_keeps_in, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_rx_byte), "waiting word lost in input stage")

endmodule

`default_nettype wire

// ----- src/stg_cfg_regs.sv -----
// Configuration registers of the stepper tone generator.
`default_nettype none

module stg_cfg_regs (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [stg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [stg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output stg_pkg::t_cfg                      o_cfg
);
    import stg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_turn      <= RST_LOW_TURN;
            r_cfg.high_turn     <= RST_HIGH_TURN;
            r_cfg.center_pos    <= RST_CENTER_POS;
            r_cfg.home_steps    <= RST_HOME_STEPS;
            r_cfg.home_interval <= RST_HOME_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_TURN: begin
                    r_cfg.low_turn <= i_cfg_wdata[7:0];
                end
                CFG_HIGH_TURN: begin
                    r_cfg.high_turn <= i_cfg_wdata[7:0];
                end
                CFG_CENTER_POS: begin
                    r_cfg.center_pos <= i_cfg_wdata[7:0];
                end
                CFG_HOME_STEPS: begin
                    r_cfg.home_steps <= i_cfg_wdata[7:0];
                end
                CFG_HOME_INTERVAL: begin
                    r_cfg.home_interval <= i_cfg_wdata[15:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/stg_engine.sv -----
// Parser, tone timer and homing sequencer state with its one-word update.
`default_nettype none

`include "stepper_tone_generator_assert.svh"

module stg_engine (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire                  i_req_type,
    input  wire  [7:0]           i_rx_byte,
    input  wire  stg_pkg::t_cfg  i_cfg,
    output stg_pkg::t_result     o_res
);
    import stg_pkg::*;

    logic [1:0]  r_parse_phase, n_parse_phase;
    logic [7:0]  r_period_high, n_period_high;
    logic [15:0] r_tone_period, n_tone_period;
    logic [15:0] r_tick_count,  n_tick_count;
    logic        r_running,     n_running;
    logic [7:0]  r_tone_mode,   n_tone_mode;
    logic [7:0]  r_head_pos,    n_head_pos;
    logic        r_bounce_dir,  n_bounce_dir;
    logic        r_step_level,  n_step_level;
    logic        r_dir_level,   n_dir_level;
    logic [1:0]  r_home_phase,  n_home_phase;
    logic [7:0]  r_home_left,   n_home_left;
    logic [15:0] r_home_wait,   n_home_wait;
    logic        n_dropped;
    logic        w_homing;
    logic        w_next_homing;

    assign w_homing      = (r_home_phase == HP_DOWN) || (r_home_phase == HP_UP);
    assign w_next_homing = (n_home_phase == HP_DOWN) || (n_home_phase == HP_UP);

    always_comb begin
        n_parse_phase = r_parse_phase;
        n_period_high = r_period_high;
        n_tone_period = r_tone_period;
        n_tick_count  = r_tick_count;
        n_running     = r_running;
        n_tone_mode   = r_tone_mode;
        n_head_pos    = r_head_pos;
        n_bounce_dir  = r_bounce_dir;
        n_step_level  = r_step_level;
        n_dir_level   = r_dir_level;
        n_home_phase  = r_home_phase;
        n_home_left   = r_home_left;
        n_home_wait   = r_home_wait;
        n_dropped     = 1'b0;

        if (i_req_type == REQ_TICK) begin
            if (w_homing) begin
                if (r_home_wait != 16'd0) begin
                    n_home_wait = r_home_wait - 16'd1;
                end else begin
                    // down phase used up: turn around and go on at once
                    if (r_home_phase == HP_DOWN && r_home_left == 8'd0) begin
                        n_home_phase = HP_UP;
                        n_dir_level  = 1'b0;
                        n_head_pos   = 8'd0;
                        n_home_left  = i_cfg.center_pos;
                    end
                    if (n_home_phase == HP_UP && n_home_left == 8'd0) begin
                        n_home_phase = HP_DONE;
                    end else begin
                        n_step_level = ~r_step_level;
                        n_home_left  = n_home_left - 8'd1;
                        if (n_home_phase == HP_UP) begin
                            n_head_pos = n_head_pos + 8'd1;
                        end
                        n_home_wait = (i_cfg.home_interval == 16'd0) ? 16'd0
                                    : i_cfg.home_interval - 16'd1;
                    end
                end
            end else if (r_running) begin
                if (r_tick_count == r_tone_period) begin
                    n_tick_count = 16'd0;
                    n_step_level = ~r_step_level;
                    if (r_tone_mode == MODE_OSC) begin
                        if (!r_step_level) begin
                            n_dir_level = ~r_dir_level;
                        end
                    end else begin
                        n_dir_level = r_bounce_dir;
                        if (!r_bounce_dir) begin
                            n_head_pos = r_head_pos + 8'd1;
                            if (n_head_pos > i_cfg.high_turn) begin
                                n_bounce_dir = 1'b1;
                            end
                        end else begin
                            n_head_pos = r_head_pos - 8'd1;
                            if (n_head_pos < i_cfg.low_turn) begin
                                n_bounce_dir = 1'b0;
                            end
                        end
                    end
                end else if (r_tick_count > r_tone_period) begin
                    // period lowered under the count: restart without a step
                    n_tick_count = 16'd0;
                end else begin
                    n_tick_count = r_tick_count + 16'd1;
                end
            end
        end else if (w_homing) begin
            n_dropped = 1'b1;
        end else begin
            case (r_parse_phase)
                PH_HIGH: begin
                    n_period_high = i_rx_byte;
                    n_parse_phase = PH_LOW;
                end
                PH_LOW: begin
                    n_tone_period = {r_period_high, i_rx_byte};
                    n_running     = 1'b1;
                    n_parse_phase = PH_CMD;
                end
                PH_MODE: begin
                    n_tone_mode   = i_rx_byte;
                    n_parse_phase = PH_CMD;
                end
                default: begin
                    n_parse_phase = PH_CMD;
                    case (i_rx_byte)
                        CMD_STOP: begin
                            n_running = 1'b0;
                        end
                        CMD_PLAY: begin
                            n_parse_phase = PH_HIGH;
                        end
                        CMD_INSTR: begin
                            n_parse_phase = PH_MODE;
                        end
                        CMD_TOGGLE_DIR: begin
                            n_bounce_dir = ~r_bounce_dir;
                        end
                        CMD_RESET: begin
                            n_running    = 1'b0;
                            n_dir_level  = 1'b1;
                            n_home_phase = HP_DOWN;
                            n_home_left  = i_cfg.home_steps;
                            n_home_wait  = 16'd0;
                        end
                        default: begin
                            // ignore unknown commands
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_phase <= PH_CMD;
            r_period_high <= 8'd0;
            r_tone_period <= RST_TONE_PERIOD;
            r_tick_count  <= 16'd0;
            r_running     <= 1'b0;
            r_tone_mode   <= MODE_OSC;
            r_head_pos    <= 8'd0;
            r_bounce_dir  <= 1'b0;
            r_step_level  <= 1'b0;
            r_dir_level   <= 1'b1;
            r_home_phase  <= HP_DOWN;
            r_home_left   <= RST_HOME_STEPS;
            r_home_wait   <= 16'd0;
        end else if (i_fire) begin
            r_parse_phase <= n_parse_phase;
            r_period_high <= n_period_high;
            r_tone_period <= n_tone_period;
            r_tick_count  <= n_tick_count;
            r_running     <= n_running;
            r_tone_mode   <= n_tone_mode;
            r_head_pos    <= n_head_pos;
            r_bounce_dir  <= n_bounce_dir;
            r_step_level  <= n_step_level;
            r_dir_level   <= n_dir_level;
            r_home_phase  <= n_home_phase;
            r_home_left   <= n_home_left;
            r_home_wait   <= n_home_wait;
        end
    end

    assign o_res.step_out     = n_step_level;
    assign o_res.dir_out      = n_dir_level;
    assign o_res.homing_busy  = w_next_homing;
    assign o_res.byte_dropped = n_dropped;

    `STG_ASSERT_NOW(a_no_tone_while_homing, i_clk, i_rst_n, w_homing, !r_running, "tone timer runs during homing")
    `STG_ASSERT_NOW(a_drop_only_homing, i_clk, i_rst_n, i_fire && o_res.byte_dropped, o_res.homing_busy, "byte dropped outside homing")
    `STG_ASSERT_NEXT(a_homing_ends_on_tick, i_clk, i_rst_n, i_fire && w_homing && !w_next_homing, $past(i_req_type) == REQ_TICK, "homing ended on a byte")

endmodule

`default_nettype wire

// ----- sim/stepper_tone_generator_tb.sv -----
// Testbench of the stepper tone generator: directed rows, then random words checked by a predictor.
`default_nettype none

module stepper_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam t_result NO_PINS = '0;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       typed;
        logic       settle;
        t_result    want;
    } t_row;

    // Rows marked typed carry the pin levels right after reset; settle ticks homing out.
    localparam t_row DIRECTED_ROWS [24] = '{
        '{REQ_BYTE, CMD_PLAY,       1'b1, 1'b0, t_result'{1'b0, 1'b1, 1'b1, 1'b1}},
        '{REQ_TICK, 8'h00,          1'b1, 1'b1, t_result'{1'b1, 1'b1, 1'b1, 1'b0}},
        '{REQ_BYTE, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'hFF,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_PLAY,       1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'h03,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'hFF,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_PLAY,       1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_INSTR,      1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'hFF,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'hFF,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_TOGGLE_DIR, 1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_STOP,       1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, CMD_RESET,      1'b0, 1'b0, NO_PINS},
        '{REQ_BYTE, 8'hFF,          1'b0, 1'b0, NO_PINS},
        '{REQ_TICK, 8'h00,          1'b0, 1'b1, NO_PINS}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    stg_in_if in_if ();
    stg_out_if out_if ();

    stepper_tone_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    t_result expected_pins_q [$];

    // predictor state
    t_cfg        m_cfg;
    logic [1:0]  m_parse, m_home_ph;
    logic [7:0]  m_period_hi, m_mode, m_pos, m_home_left;
    logic [15:0] m_period, m_ticks, m_home_wait;
    logic        m_running, m_bounce, m_step, m_dir;

    function automatic logic in_homing();
        return m_home_ph == HP_DOWN || m_home_ph == HP_UP;
    endfunction

    function automatic void arm_homing();
        m_running   = 1'b0;
        m_dir       = 1'b1;
        m_home_ph   = HP_DOWN;
        m_home_left = m_cfg.home_steps;
        m_home_wait = 16'd0;
    endfunction

    function automatic void reset_tone_model();
        m_cfg = '{RST_LOW_TURN, RST_HIGH_TURN, RST_CENTER_POS, RST_HOME_STEPS,
                  RST_HOME_INTERVAL};
        m_parse     = PH_CMD;
        m_period_hi = 8'd0;
        m_period    = RST_TONE_PERIOD;
        m_ticks     = 16'd0;
        m_running   = 1'b0;
        m_mode      = MODE_OSC;
        m_pos       = 8'd0;
        m_bounce    = 1'b0;
        m_step      = 1'b0;
        m_dir       = 1'b0;
        arm_homing();
    endfunction

    function automatic void step_homing();
        if (m_home_wait != 16'd0) begin
            m_home_wait = m_home_wait - 16'd1;
        end else begin
            // down run used up: turn around and count the way back to center
            if (m_home_ph == HP_DOWN && m_home_left == 8'd0) begin
                m_home_ph   = HP_UP;
                m_dir       = 1'b0;
                m_pos       = 8'd0;
                m_home_left = m_cfg.center_pos;
            end
            if (m_home_ph == HP_UP && m_home_left == 8'd0) begin
                m_home_ph = HP_DONE;
            end else begin
                m_step      = ~m_step;
                m_home_left = m_home_left - 8'd1;
                if (m_home_ph == HP_UP) begin
                    m_pos = m_pos + 8'd1;
                end
                m_home_wait = (m_cfg.home_interval == 16'd0) ? 16'd0
                                                             : m_cfg.home_interval - 16'd1;
            end
        end
    endfunction

    function automatic void pulse_tone();
        m_step = ~m_step;
        if (m_mode == MODE_OSC) begin
            if (m_step) begin
                m_dir = ~m_dir;
            end
        end else begin
            m_dir = m_bounce;
            if (!m_bounce) begin
                m_pos = m_pos + 8'd1;
                if (m_pos > m_cfg.high_turn) begin
                    m_bounce = ~m_bounce;
                end
            end else begin
                m_pos = m_pos - 8'd1;
                if (m_pos < m_cfg.low_turn) begin
                    m_bounce = ~m_bounce;
                end
            end
        end
    endfunction

    function automatic void count_tone();
        if (m_running) begin
            if (m_ticks == m_period) begin
                m_ticks = 16'd0;
                pulse_tone();
            end else if (m_ticks > m_period) begin
                m_ticks = 16'd0;
            end else begin
                m_ticks = m_ticks + 16'd1;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (m_parse)
            PH_HIGH: begin
                m_period_hi = b;
                m_parse     = PH_LOW;
            end
            PH_LOW: begin
                m_period  = {m_period_hi, b};
                m_running = 1'b1;
                m_parse   = PH_CMD;
            end
            PH_MODE: begin
                m_mode  = b;
                m_parse = PH_CMD;
            end
            default: begin
                m_parse = PH_CMD;
                case (b)
                    CMD_STOP:       m_running = 1'b0;
                    CMD_PLAY:       m_parse = PH_HIGH;
                    CMD_INSTR:      m_parse = PH_MODE;
                    CMD_TOGGLE_DIR: m_bounce = ~m_bounce;
                    CMD_RESET:      arm_homing();
                    default:        ;
                endcase
            end
        endcase
    endfunction

    function automatic t_result predict_pins(input logic req, input logic [7:0] b);
        t_result r;
        r.byte_dropped = 1'b0;
        if (req == REQ_TICK) begin
            if (in_homing()) begin
                step_homing();
            end else begin
                count_tone();
            end
        end else if (in_homing()) begin
            r.byte_dropped = 1'b1;
        end else begin
            parse_byte(b);
        end
        r.step_out    = m_step;
        r.dir_out     = m_dir;
        r.homing_busy = in_homing();
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOW_TURN:      m_cfg.low_turn = val[7:0];
            CFG_HIGH_TURN:     m_cfg.high_turn = val[7:0];
            CFG_CENTER_POS:    m_cfg.center_pos = val[7:0];
            CFG_HOME_STEPS:    m_cfg.home_steps = val[7:0];
            CFG_HOME_INTERVAL: m_cfg.home_interval = val;
            default:           ;
        endcase
    endtask

    task automatic set_turns(input logic [7:0] low, input logic [7:0] high,
                             input logic [7:0] center, input logic [7:0] steps,
                             input logic [15:0] interval);
        write_reg(CFG_LOW_TURN, {8'd0, low});
        write_reg(CFG_HIGH_TURN, {8'd0, high});
        write_reg(CFG_CENTER_POS, {8'd0, center});
        write_reg(CFG_HOME_STEPS, {8'd0, steps});
        write_reg(CFG_HOME_INTERVAL, interval);
    endtask

    task automatic send_word(input logic req, input logic [7:0] b,
                             input logic typed, input t_result want);
        t_result guess;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid    <= 1'b1;
        in_if.req_type <= req;
        in_if.rx_byte  <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        guess = predict_pins(req, b);
        expected_pins_q.insert(expected_pins_q.size(), typed ? want : guess);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_pins_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_homing();
        while (in_homing()) send_word(REQ_TICK, 8'($urandom_range(255)), 1'b0, NO_PINS);
    endtask

    // Run the homing sequence from its start under the current settings.
    task automatic rehome();
        finish_homing();
        while (m_parse != PH_CMD) send_word(REQ_BYTE, 8'($urandom_range(255)), 1'b0, NO_PINS);
        send_word(REQ_BYTE, CMD_RESET, 1'b0, NO_PINS);
        finish_homing();
    endtask

    task automatic send_random_word();
        int unsigned roll;
        logic [7:0] b;
        roll = $urandom_range(99);
        b = 8'($urandom_range(255));
        if (in_homing()) begin
            send_word((roll < 85) ? REQ_TICK : REQ_BYTE, b, 1'b0, NO_PINS);
        end else if (m_parse == PH_HIGH) begin
            // keep periods short most of the time so the pin toggles
            if (roll < 70) b = 8'($urandom_range(1));
            send_word(REQ_BYTE, b, 1'b0, NO_PINS);
        end else if (m_parse == PH_LOW) begin
            if (roll < 60) b = 8'($urandom_range(7));
            send_word(REQ_BYTE, b, 1'b0, NO_PINS);
        end else if (m_parse == PH_MODE) begin
            if (roll < 50) b = MODE_OSC;
            send_word(REQ_BYTE, b, 1'b0, NO_PINS);
        end else if (roll < 55) begin
            send_word(REQ_TICK, b, 1'b0, NO_PINS);
        end else begin
            roll = $urandom_range(99);
            if (roll < 30)      b = CMD_PLAY;
            else if (roll < 45) b = CMD_INSTR;
            else if (roll < 55) b = CMD_STOP;
            else if (roll < 70) b = CMD_TOGGLE_DIR;
            else if (roll < 73) b = CMD_RESET;
            send_word(REQ_BYTE, b, 1'b0, NO_PINS);
        end
    endtask

    task automatic run_random(input int unsigned count, input logic pause_midway);
        for (int unsigned k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) begin
                drain_results();
            end
            send_random_word();
        end
    endtask

    function automatic void check_pin(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_pins_q.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = expected_pins_q.pop_front();
                check_pin("step_out", want.step_out, out_if.step_out);
                check_pin("dir_out", want.dir_out, out_if.dir_out);
                check_pin("homing_busy", want.homing_busy, out_if.homing_busy);
                check_pin("byte_dropped", want.byte_dropped, out_if.byte_dropped);
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stop the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_LOW_TURN;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.req_type = REQ_BYTE;
        in_if.rx_byte  = 8'd0;
        out_if.ready   = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 10;
        recv_idle_pct  = 50;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reset_tone_model();

        // shorten homing pace and runs; the power-up down run keeps its length
        write_reg(CFG_HOME_INTERVAL, 16'd1);
        write_reg(CFG_CENTER_POS, 16'd2);
        write_reg(CFG_HOME_STEPS, 16'd2);
        foreach (DIRECTED_ROWS[r]) begin
            send_word(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].data,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
            if (DIRECTED_ROWS[r].settle) begin
                finish_homing();
            end
        end
        drain_results();

        set_turns(8'd25, 8'd35, 8'd10, 8'd3, 16'd2);
        rehome();
        run_random(70, 1'b1);
        drain_results();

        send_idle_pct = 50;
        recv_idle_pct = 10;
        set_turns(8'd0, 8'd255, 8'd0, 8'd0, 16'd0);
        rehome();
        run_random(70, 1'b0);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // one longer homing wait after a single down toggle
        set_turns(8'd30, 8'd130, 8'd0, 8'd1, 16'd40);
        rehome();
        drain_results();

        set_turns(8'd255, 8'd0, 8'd4, 8'd2, 16'd1);
        rehome();
        run_random(35, 1'b0);
        drain_results();

        set_turns(8'd20, 8'd60, 8'd12, 8'd8, 16'd3);
        rehome();
        run_random(35, 1'b0);
        drain_results();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
